### rtl/utf8_validating_decoder_top_macros.svh
// assertion macros for the utf-8 validating decoder
// no dependencies; included by the top level
`ifndef UTF8_VALIDATING_DECODER_TOP_MACROS_SVH
`define UTF8_VALIDATING_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define UVD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8 decoder: implication check failed");
// antecedent implies consequent in the next cycle
`define UVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8 decoder: next-cycle check failed");
`else
`define UVD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define UVD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/utf8vd_pkg.sv
// constants, types and helpers for the utf-8 validating decoder
// no dependencies
`timescale 1ns / 1ps

package utf8vd_pkg;

   localparam int CP_W  = 21;
   localparam int LEN_W = 3;

   localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
   localparam logic [CP_W-1:0] NONCHAR0 = 21'h00FFFE;
   localparam logic [CP_W-1:0] NONCHAR1 = 21'h00FFFF;
   localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;

   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;
   localparam logic [7:0] LEAD_BAD  = 8'hF8;
   localparam logic [7:0] LEAD_3B   = 8'hE0;
   localparam logic [7:0] LEAD_4B   = 8'hF0;

   typedef struct packed {
      logic            valid;
      logic [CP_W-1:0] code_point;
      logic [LEN_W-1:0] seq_length;
      logic            error;
   } result_type;

   // smallest legal value for a sequence with n trailing bytes
   function automatic logic [CP_W-1:0] min_code(input logic [1:0] n);
      logic [CP_W-1:0] m;
      unique case (n)
         2'd0: m = 21'h000000;
         2'd1: m = 21'h000080;
         2'd2: m = 21'h000800;
         default: m = 21'h010000;
      endcase
      return m;
   endfunction

   // payload bits of a lead byte announcing n trailing bytes
   function automatic logic [CP_W-1:0] lead_bits(input logic [7:0] b, input logic [1:0] n);
      logic [CP_W-1:0] v;
      unique case (n)
         2'd0: v = {14'd0, b[6:0]};
         2'd1: v = {16'd0, b[4:0]};
         2'd2: v = {17'd0, b[3:0]};
         default: v = {18'd0, b[2:0]};
      endcase
      return v;
   endfunction

endpackage

### rtl/utf8_validating_decoder_top.sv
// utf-8 validating decoder, top level
// depends on utf8vd_pkg and utf8_validating_decoder_top_macros.svh
`timescale 1ns / 1ps
//
// usage
// - request channel (req_valid / req_ready / req_data_byte) carries one raw
//   byte of a utf-8 stream per request
// - result channel (rsp_valid / rsp_ready / rsp_*) carries one decoded code
//   point with its byte length, or an error with the number of bytes dropped
// - bytes inside an open multi-byte sequence give no result; the last byte
//   of a sequence (or the byte that breaks it) gives exactly one
// - a byte is registered at the input, decoded against the sequence state
//   and its result is registered in the result register
// - throughput: one byte per clock unless the result channel stalls; the
//   path between the input register and the result register is one shift,
//   a few compares and a small mux
// - a stalled result register holds its item; the input register keeps one
//   more byte, after which req_ready drops until rsp_ready returns
// - synchronous reset clears both registers and returns the sequence state
//   to idle
//
`include "utf8_validating_decoder_top_macros.svh"

module utf8_validating_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic [2:0]  rsp_seq_length,
   output logic        rsp_error
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;

   // sequence state
   logic [utf8vd_pkg::CP_W-1:0] partial_ff, partial_in;
   logic [1:0]                  remain_ff,  remain_in;
   logic [1:0]                  total_ff,   total_in;

   // result register
   utf8vd_pkg::result_type rsp_ff, rsp_in;

   logic advance;
   logic is_cont;
   logic [utf8vd_pkg::CP_W-1:0] shifted;
   logic [1:0] lead_n;
   logic [1:0] remain_dec;
   logic [1:0] got;
   logic bad_value;
   utf8vd_pkg::result_type res;

   // decode the held byte when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_ff.valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end
   end

   // decode
   assign is_cont    = (in_byte_ff & utf8vd_pkg::CONT_MASK) == utf8vd_pkg::CONT_TAG;
   assign shifted    = {partial_ff[utf8vd_pkg::CP_W-7:0], in_byte_ff[5:0]};
   assign remain_dec = remain_ff - 2'd1;
   assign got        = total_ff - remain_ff;

   always_comb begin
      priority if (in_byte_ff < utf8vd_pkg::LEAD_3B) begin
         lead_n = 2'd1;
      end else if (in_byte_ff < utf8vd_pkg::LEAD_4B) begin
         lead_n = 2'd2;
      end else begin
         lead_n = 2'd3;
      end
   end

   // overlong, surrogate, the two noncharacters and out of range
   assign bad_value = (shifted < utf8vd_pkg::min_code(total_ff))
                   || ((shifted >= utf8vd_pkg::SURR_LO) && (shifted <= utf8vd_pkg::SURR_HI))
                   || (shifted == utf8vd_pkg::NONCHAR0)
                   || (shifted == utf8vd_pkg::NONCHAR1)
                   || (shifted > utf8vd_pkg::MAX_CP);

   always_comb begin
      res        = '0;
      partial_in = partial_ff;
      remain_in  = remain_ff;
      total_in   = total_ff;
      if (remain_ff == 2'd0) begin
         priority if (is_cont || (in_byte_ff >= utf8vd_pkg::LEAD_BAD)) begin
            // stray continuation or impossible lead
            res.valid      = 1'b1;
            res.seq_length = 3'd1;
            res.error      = 1'b1;
         end else if (!in_byte_ff[7]) begin
            // ascii
            res.valid      = 1'b1;
            res.code_point = {13'd0, in_byte_ff};
            res.seq_length = 3'd1;
         end else begin
            // lead byte opens a sequence
            partial_in = utf8vd_pkg::lead_bits(in_byte_ff, lead_n);
            remain_in  = lead_n;
            total_in   = lead_n;
         end
      end else if (!is_cont) begin
         // sequence broken: drop it and the offending byte
         res.valid      = 1'b1;
         res.seq_length = {1'b0, got} + 3'd2;
         res.error      = 1'b1;
         partial_in     = '0;
         remain_in      = 2'd0;
         total_in       = 2'd0;
      end else begin
         partial_in = shifted;
         remain_in  = remain_dec;
         if (remain_dec == 2'd0) begin
            res.valid      = 1'b1;
            res.seq_length = {1'b0, total_ff} + 3'd1;
            res.error      = bad_value;
            res.code_point = bad_value ? '0 : shifted;
            partial_in     = '0;
            total_in       = 2'd0;
         end
      end
   end

   // result register loads on decode, clears when taken
   always_comb begin
      rsp_in = rsp_ff;
      if (rsp_ff.valid && rsp_ready) begin
         rsp_in.valid = 1'b0;
      end
      if (advance) begin
         rsp_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         remain_ff    <= 2'd0;
         total_ff     <= 2'd0;
         partial_ff   <= '0;
         rsp_ff.valid <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_ff.valid <= rsp_in.valid;
         if (advance) begin
            remain_ff  <= remain_in;
            total_ff   <= total_in;
            partial_ff <= partial_in;
         end
      end
      // payload registers, no reset
      in_byte_ff        <= in_byte_in;
      rsp_ff.code_point <= rsp_in.code_point;
      rsp_ff.seq_length <= rsp_in.seq_length;
      rsp_ff.error      <= rsp_in.error;
   end

   assign rsp_valid      = rsp_ff.valid;
   assign rsp_code_point = rsp_ff.code_point;
   assign rsp_seq_length = rsp_ff.seq_length;
   assign rsp_error      = rsp_ff.error;

   // checks
   `UVD_ASSERT_IMPLY(a_err_zero_cp, clock, reset,
      rsp_valid && rsp_error, rsp_code_point == 21'd0)
   `UVD_ASSERT_IMPLY(a_len_range, clock, reset,
      rsp_valid, (rsp_seq_length != 3'd0) && (rsp_seq_length <= 3'd4))
   `UVD_ASSERT_IMPLY(a_cp_range, clock, reset,
      rsp_valid && !rsp_error, rsp_code_point <= utf8vd_pkg::MAX_CP)
   `UVD_ASSERT_IMPLY(a_remain_le_total, clock, reset,
      remain_ff != 2'd0, remain_ff <= total_ff)
   `UVD_ASSERT_NEXT(a_stall_holds_state, clock, reset,
      in_valid_ff && rsp_valid && !rsp_ready, $stable(remain_ff) && $stable(partial_ff))

endmodule
